// File: sv/jblt_pkg.sv
// ----------------------------------------------------------------------------
// jblt_pkg
// Shared widths, register map and reset values for the single-wire line
// transceiver.
// ----------------------------------------------------------------------------
package jblt_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned UNIT_W   = 6;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [PADDR_W-1:0] paddr_t;
  typedef logic [PDATA_W-1:0] pdata_t;
  typedef logic [UNIT_W-1:0]  unit_t;

  // register index, taken from paddr[2]
  localparam logic REG_SAMPLE_DELAY = 1'b0;
  localparam logic REG_RX_LENGTH    = 1'b1;

  localparam data_t SAMPLE_DELAY_RST = 8'd16;
  localparam len_t  RX_LENGTH_RST    = 7'd4;
  localparam len_t  BYTE_COUNT_MAX   = 7'h7f;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TX     = 1'b1;

  // last time unit of a byte, and of a byte followed by the stop bit
  localparam unit_t UNIT_LAST_BYTE = 6'd31;
  localparam unit_t UNIT_STOP_LOW  = 6'd32;
  localparam unit_t UNIT_LAST_STOP = 6'd33;

endpackage

// File: sv/joybus_line_transceiver.sv
// ----------------------------------------------------------------------------
// joybus_line_transceiver
// Half-duplex pulse-width line codec: serializes transmit bytes into timed
// units and decodes sampled line levels into bytes and frame completion.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid / in_ready     command, line_level, tx_byte, tx_last
//  out      output     out_valid / out_ready   drive_low, drive_valid, rx_byte,
//                                              rx_valid, frame_done, run_last
//  cfg      input      APB psel/penable/pready sample_delay @0x0, rx_length @0x4
//
//  A sample beat gives one result beat, a transmit beat 32 (34 with the stop bit),
//  one per cycle while out_ready holds, via the input register and output stage.
//  Sample beats stream at one per cycle while out_ready holds; behind a transmit
//  run one beat waits in the input register and in_ready drops until the run's
//  last unit goes. Receiver state advances as an item moves into the output stage.
//  rst_n is synchronous, active low; pready is always high.
module joybus_line_transceiver
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_command,
  input  logic             in_line_level,
  input  jblt_pkg::data_t  in_tx_byte,
  input  logic             in_tx_last,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_drive_low,
  output logic             out_drive_valid,
  output jblt_pkg::data_t  out_rx_byte,
  output logic             out_rx_valid,
  output logic             out_frame_done,
  output logic             out_run_last,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  jblt_pkg::paddr_t paddr,
  input  jblt_pkg::pdata_t pwdata,
  output jblt_pkg::pdata_t prdata,
  output logic             pready
);
  import jblt_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT_LOW  = 3'd0,
    PH_DELAY     = 3'd1,
    PH_WAIT_HIGH = 3'd2,
    PH_STOP_HIGH = 3'd3
  } phase_t;

  // configuration
  data_t sample_delay_r;
  len_t  rx_length_r;

  // input register
  logic  hold_v_r;
  logic  hold_cmd_r;
  logic  hold_lvl_r;
  data_t hold_byte_r;
  logic  hold_last_r;

  // output stage
  logic  ob_v_r;
  logic  ob_tx_r;
  data_t ob_byte_r;
  logic  ob_last_r;
  unit_t ob_unit_r;
  data_t ob_rxbyte_r;
  logic  ob_rxv_r;
  logic  ob_done_r;

  // receiver
  phase_t phase_r,  phase_nxt;
  data_t  dcnt_r,   dcnt_nxt;
  data_t  shift_r,  shift_nxt;
  logic [2:0] bcnt_r, bcnt_nxt;
  len_t   bytes_r,  bytes_nxt;
  logic   got_nxt;
  logic   done_nxt;
  data_t  rxbyte_nxt;

  logic   in_fire;
  logic   out_fire;
  logic   load;
  logic   cfg_wr;
  data_t  target;
  data_t  dcnt_inc;
  data_t  shift_in;
  logic [2:0] bcnt_inc;
  logic   tx_bit;
  logic [1:0] unit_pos;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_RX_LENGTH)
                    ? pdata_t'(rx_length_r) : pdata_t'(sample_delay_r);

  assign out_fire = out_valid && out_ready;
  assign load     = hold_v_r && (!ob_v_r || (out_ready && out_run_last));
  assign in_ready = !hold_v_r || load;
  assign in_fire  = in_valid && in_ready;

  // result decode from the output stage
  assign unit_pos = ob_unit_r[1:0];
  assign tx_bit   = ob_byte_r[3'd7 - ob_unit_r[4:2]];

  always_comb begin
    out_valid       = ob_v_r;
    out_drive_valid = ob_tx_r;
    out_rx_byte     = ob_tx_r ? '0 : ob_rxbyte_r;
    out_rx_valid    = !ob_tx_r && ob_rxv_r;
    out_frame_done  = !ob_tx_r && ob_done_r;
    out_drive_low   = 1'b0;
    out_run_last    = 1'b1;
    if (ob_tx_r) begin
      if (ob_unit_r == UNIT_STOP_LOW) begin
        out_drive_low = 1'b1;
      end else if (ob_unit_r == UNIT_LAST_STOP) begin
        out_drive_low = 1'b0;
      end else begin
        // a one is low for one unit, a zero for three
        out_drive_low = (unit_pos == 2'd0) || (!tx_bit && (unit_pos != 2'd3));
      end
      out_run_last = ob_unit_r == (ob_last_r ? UNIT_LAST_STOP : UNIT_LAST_BYTE);
    end
  end

  // receiver next state for the item in the input register
  assign target   = (sample_delay_r == '0) ? 8'd1 : sample_delay_r;
  assign dcnt_inc = dcnt_r + 8'd1;
  assign shift_in = {shift_r[DATA_W-2:0], hold_lvl_r};
  assign bcnt_inc = bcnt_r + 3'd1;

  always_comb begin
    phase_nxt  = phase_r;
    dcnt_nxt   = dcnt_r;
    shift_nxt  = shift_r;
    bcnt_nxt   = bcnt_r;
    bytes_nxt  = bytes_r;
    got_nxt    = 1'b0;
    done_nxt   = 1'b0;
    rxbyte_nxt = '0;
    if (hold_cmd_r == CMD_TX) begin
      phase_nxt = PH_WAIT_LOW;
      dcnt_nxt  = '0;
      shift_nxt = '0;
      bcnt_nxt  = '0;
      bytes_nxt = '0;
    end else begin
      case (phase_r)
        PH_DELAY: begin
          dcnt_nxt = dcnt_inc;
          if (dcnt_inc >= target) begin
            shift_nxt = shift_in;
            bcnt_nxt  = bcnt_inc;
            if (bcnt_inc == 3'd0) begin
              got_nxt    = 1'b1;
              rxbyte_nxt = shift_in;
              if (bytes_r < BYTE_COUNT_MAX) begin
                bytes_nxt = bytes_r + 7'd1;
              end
            end
            phase_nxt = hold_lvl_r ? PH_WAIT_LOW : PH_WAIT_HIGH;
          end
        end
        PH_WAIT_HIGH: begin
          if (hold_lvl_r) begin
            phase_nxt = PH_WAIT_LOW;
          end
        end
        PH_STOP_HIGH: begin
          if (hold_lvl_r) begin
            done_nxt  = 1'b1;
            phase_nxt = PH_WAIT_LOW;
            dcnt_nxt  = '0;
            shift_nxt = '0;
            bcnt_nxt  = '0;
            bytes_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_WAIT_LOW;
          if (!hold_lvl_r) begin
            if (bytes_r >= rx_length_r) begin
              phase_nxt = PH_STOP_HIGH;
            end else begin
              phase_nxt = PH_DELAY;
              dcnt_nxt  = '0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_delay_r <= SAMPLE_DELAY_RST;
      rx_length_r    <= RX_LENGTH_RST;
      hold_v_r       <= 1'b0;
      ob_v_r         <= 1'b0;
      ob_tx_r        <= 1'b0;
      ob_unit_r      <= '0;
      phase_r        <= PH_WAIT_LOW;
      dcnt_r         <= '0;
      shift_r        <= '0;
      bcnt_r         <= '0;
      bytes_r        <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_SAMPLE_DELAY) begin
          sample_delay_r <= pwdata[DATA_W-1:0];
        end else begin
          rx_length_r <= pwdata[LEN_W-1:0];
        end
      end

      if (in_fire) begin
        hold_v_r <= 1'b1;
      end else if (load) begin
        hold_v_r <= 1'b0;
      end

      if (load) begin
        // move the held item into the output stage
        ob_v_r    <= 1'b1;
        ob_tx_r   <= hold_cmd_r;
        ob_unit_r <= '0;
        phase_r   <= phase_nxt;
        dcnt_r    <= dcnt_nxt;
        shift_r   <= shift_nxt;
        bcnt_r    <= bcnt_nxt;
        bytes_r   <= bytes_nxt;
      end else if (out_fire) begin
        if (out_run_last) begin
          ob_v_r <= 1'b0;
        end else begin
          ob_unit_r <= ob_unit_r + 6'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_cmd_r  <= in_command;
      hold_lvl_r  <= in_line_level;
      hold_byte_r <= in_tx_byte;
      hold_last_r <= in_tx_last;
    end
    if (load) begin
      ob_byte_r   <= hold_byte_r;
      ob_last_r   <= hold_last_r;
      ob_rxbyte_r <= rxbyte_nxt;
      ob_rxv_r    <= got_nxt;
      ob_done_r   <= done_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_tx_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_valid && out_run_last |-> ob_unit_r >= UNIT_LAST_BYTE)
    else $error("transmit run ended before the last data unit");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> hold_v_r && ob_v_r)
    else $error("input stalled with a free stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_run_last && !load |=> !out_valid)
    else $error("output stage kept a finished run");

  a_tx_no_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_valid |-> !out_rx_valid && !out_frame_done)
    else $error("receive flags on a transmit unit");

  a_unit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> ob_unit_r == $past(ob_unit_r))
    else $error("unit counter moved during a stall");
`endif

endmodule

// File: tb/joybus_line_transceiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joybus_line_transceiver_tb
// Self-checking bench for the single-wire line transceiver. Transmit beats
// and line-sample beats go in over valid/ready, and every result beat is
// checked against an in-bench model of the encoder and the receive state
// machine. Registers go through the APB port and are read back. The run
// covers directed corner cases, then random traffic with well-formed frames,
// broken frames and noise under several idle and stall mixes.
// ----------------------------------------------------------------------------
module joybus_line_transceiver_tb;
  import jblt_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 10;

  typedef enum logic [2:0] {
    RX_WAIT_LOW  = 3'd0,
    RX_DELAY     = 3'd1,
    RX_WAIT_HIGH = 3'd2,
    RX_STOP_HIGH = 3'd3
  } rx_phase_t;

  typedef struct packed {
    logic  drive_low;
    logic  drive_valid;
    data_t rx_byte;
    logic  rx_valid;
    logic  frame_done;
    logic  run_last;
  } line_result_t;

  logic   clk;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   in_command = CMD_SAMPLE;
  logic   in_line_level = 1'b1;
  data_t  in_tx_byte = '0;
  logic   in_tx_last = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_drive_low;
  logic   out_drive_valid;
  data_t  out_rx_byte;
  logic   out_rx_valid;
  logic   out_frame_done;
  logic   out_run_last;
  logic   psel = 1'b0;
  logic   penable = 1'b0;
  logic   pwrite = 1'b0;
  paddr_t paddr = '0;
  pdata_t pwdata = '0;
  pdata_t prdata;
  logic   pready;

  // model state
  data_t     cfg_sample_delay;
  len_t      cfg_rx_length;
  rx_phase_t rx_phase;
  data_t     delay_count;
  data_t     shift_reg;
  logic [2:0] bit_count;
  len_t      byte_count;

  line_result_t expected_units[$];
  int error_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  joybus_line_transceiver uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_line_level   (in_line_level),
    .in_tx_byte      (in_tx_byte),
    .in_tx_last      (in_tx_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive_low   (out_drive_low),
    .out_drive_valid (out_drive_valid),
    .out_rx_byte     (out_rx_byte),
    .out_rx_valid    (out_rx_valid),
    .out_frame_done  (out_frame_done),
    .out_run_last    (out_run_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --

  function automatic void clear_receiver();
    rx_phase    = RX_WAIT_LOW;
    delay_count = '0;
    shift_reg   = '0;
    bit_count   = '0;
    byte_count  = '0;
  endfunction

  function automatic void push_tx_unit(logic low, logic last_unit);
    line_result_t r;
    r = '0;
    r.drive_low   = low;
    r.drive_valid = 1'b1;
    r.run_last    = last_unit;
    expected_units.push_back(r);
  endfunction

  function automatic void predict_line_item(logic cmd, logic level, data_t tx_byte,
                                            logic tx_last);
    line_result_t r;
    data_t bits;
    data_t target;
    int b;
    int u;
    if (cmd == CMD_TX) begin
      clear_receiver();
      bits = tx_byte;
      for (b = 0; b < 8; b++) begin
        for (u = 0; u < 4; u++)
          push_tx_unit(u < (bits[7] ? 1 : 3), !tx_last && b == 7 && u == 3);
        bits = bits << 1;
      end
      if (tx_last) begin
        push_tx_unit(1'b1, 1'b0);
        push_tx_unit(1'b0, 1'b1);
      end
    end else begin
      r = '0;
      r.run_last = 1'b1;
      case (rx_phase)
        RX_DELAY: begin
          target = (cfg_sample_delay == '0) ? 8'd1 : cfg_sample_delay;
          delay_count = delay_count + 8'd1;
          if (delay_count >= target) begin
            shift_reg = {shift_reg[6:0], level};
            bit_count = bit_count + 3'd1;
            if (bit_count == 3'd0) begin
              r.rx_valid = 1'b1;
              r.rx_byte  = shift_reg;
              if (byte_count != BYTE_COUNT_MAX)
                byte_count = byte_count + 7'd1;
            end
            // a high sample means the line is already released
            if (level)
              rx_phase = RX_WAIT_LOW;
            else
              rx_phase = RX_WAIT_HIGH;
          end
        end
        RX_WAIT_HIGH: begin
          if (level)
            rx_phase = RX_WAIT_LOW;
        end
        RX_STOP_HIGH: begin
          if (level) begin
            r.frame_done = 1'b1;
            clear_receiver();
          end
        end
        default: begin
          rx_phase = RX_WAIT_LOW;
          if (!level) begin
            if (byte_count >= cfg_rx_length) begin
              rx_phase = RX_STOP_HIGH;
            end else begin
              rx_phase    = RX_DELAY;
              delay_count = '0;
            end
          end
        end
      endcase
      expected_units.push_back(r);
    end
  endfunction

  // -------------------------------------------------------------- drivers --

  task automatic send_item(logic cmd, logic level, data_t tx_byte, logic tx_last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_line_level <= level;
    in_tx_byte    <= tx_byte;
    in_tx_last    <= tx_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_line_item(cmd, level, tx_byte, tx_last);
    items_sent++;
  endtask

  task automatic send_sample(logic level);
    send_item(CMD_SAMPLE, level, data_t'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic send_tx(data_t value, logic last);
    send_item(CMD_TX, 1'($urandom_range(1)), value, last);
  endtask

  // hold the sender until every expected result beat has drained
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, pdata_t value);
    pdata_t masked;
    masked = value & ((idx == REG_SAMPLE_DELAY) ? 32'hff : 32'h7f);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_SAMPLE_DELAY)
      cfg_sample_delay = masked[DATA_W-1:0];
    else
      cfg_rx_length = masked[LEN_W-1:0];
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== masked) begin
      $error("register %0d readback: expected %0h, got %0h", idx, masked, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(pdata_t delay, pdata_t length);
    wait_for_results();
    cfg_write(REG_SAMPLE_DELAY, delay);
    cfg_write(REG_RX_LENGTH, length);
  endtask

  // one pulse cell per bit: short low for a 1, long low for a 0
  task automatic send_rx_bits(data_t value, int nbits);
    int d;
    int lo;
    int hi;
    int b;
    int k;
    d = (cfg_sample_delay == '0) ? 1 : int'(cfg_sample_delay);
    for (b = 7; b > 7 - nbits; b--) begin
      lo = value[b] ? $urandom_range(d, 1) : $urandom_range(d + 3, d + 1);
      hi = $urandom_range(3, 1);
      for (k = 0; k < lo; k++) send_sample(1'b0);
      for (k = 0; k < hi; k++) send_sample(1'b1);
    end
  endtask

  task automatic send_rx_stop();
    int k;
    int n;
    n = $urandom_range(2, 1);
    for (k = 0; k < n; k++) send_sample(1'b0);
    n = $urandom_range(2, 1);
    for (k = 0; k < n; k++) send_sample(1'b1);
  endtask

  task automatic send_line_idle();
    int k;
    int n;
    n = $urandom_range(3, 1);
    for (k = 0; k < n; k++) send_sample(1'b1);
  endtask

  // ---------------------------------------------------------------- tests --

  task automatic test_tx_patterns();
    send_tx(8'h00, 1'b0);
    send_tx(8'hff, 1'b1);
    send_tx(8'h80, 1'b1);
    send_tx(8'h01, 1'b0);
  endtask

  task automatic test_rx_corners();
    // no bytes expected: first low goes straight to the stop wait
    set_config(32'd0, 32'd0);
    send_sample(1'b0);
    send_sample(1'b1);
    // zero delay acts as one; a high bit skips the wait for high
    set_config(32'd0, 32'd1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);
    // transmit in mid-bit drops the receiver back to idle
    send_sample(1'b0);
    send_tx(8'h3c, 1'b0);
    send_sample(1'b0);
    send_sample(1'b1);
  endtask

  task automatic test_config_extremes();
    set_config(32'd255, 32'd64);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_tx(8'h5a, 1'b1);
    set_config(32'd1, 32'd127);
    send_sample(1'b0);
    send_sample(1'b1);
    send_tx(8'ha5, 1'b0);
  endtask

  task automatic test_length_cut();
    set_config(32'd1, 32'd2);
    send_tx(data_t'($urandom), 1'b1);
    send_line_idle();
    send_rx_bits(data_t'($urandom), 8);
    // drop the frame length to the number of bytes already in
    set_config(32'd1, 32'd1);
    send_rx_stop();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, pdata_t delay,
                                     pdata_t length);
    int start_count;
    int pick;
    int k;
    int n;
    set_config(delay, length);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_count = items_sent;
    while (items_sent - start_count < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // request then response frame
        send_tx(data_t'($urandom), 1'b1);
        send_line_idle();
        for (k = 0; k < int'(cfg_rx_length); k++)
          send_rx_bits(data_t'($urandom), 8);
        send_rx_stop();
      end else if (pick < 65) begin
        send_tx(data_t'($urandom), 1'($urandom_range(1)));
      end else if (pick < 80) begin
        n = $urandom_range(6, 1);
        for (k = 0; k < n; k++) send_sample(1'($urandom_range(1)));
      end else if (pick < 92) begin
        // broken frame: a few bits then whatever follows
        send_line_idle();
        send_rx_bits(data_t'($urandom), $urandom_range(5, 1));
        if ($urandom_range(1))
          send_tx(data_t'($urandom), 1'($urandom_range(1)));
      end else begin
        send_tx(data_t'($urandom), 1'b1);
        send_line_idle();
        send_rx_bits(data_t'($urandom), 8);
        set_config(delay, pdata_t'($urandom_range(1)));
        send_rx_stop();
        set_config(delay, length);
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // -------------------------------------------------------------- checker --

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_units.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        want = expected_units.pop_front();
        check_field("drive_low", 8'(want.drive_low), 8'(out_drive_low));
        check_field("drive_valid", 8'(want.drive_valid), 8'(out_drive_valid));
        check_field("rx_byte", want.rx_byte, out_rx_byte);
        check_field("rx_valid", 8'(want.rx_valid), 8'(out_rx_valid));
        check_field("frame_done", 8'(want.frame_done), 8'(out_frame_done));
        check_field("run_last", 8'(want.run_last), 8'(out_run_last));
      end
    end
  end

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cfg_sample_delay = SAMPLE_DELAY_RST;
    cfg_rx_length    = RX_LENGTH_RST;
    clear_receiver();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_tx_patterns();
    test_rx_corners();
    test_config_extremes();
    test_length_cut();
    test_random_traffic(0, 0, 32'd1, 32'd1);
    test_random_traffic(54, 0, 32'd2, 32'd1);
    test_random_traffic(0, 54, 32'd0, 32'd2);
    test_random_traffic(38, 38, 32'd3, 32'd1);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_units.size() != 0) begin
      $error("%0d result beats never arrived", expected_units.size());
      error_count++;
    end
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: joybus_line_transceiver.f
sv/jblt_pkg.sv
sv/joybus_line_transceiver.sv
tb/joybus_line_transceiver_tb.sv
